>>> rtl/core/mpls_pkg.sv
// ----------------------------------------------------------------------------
// mpls_pkg: shared types and constants of the piecewise-linear shaper
// Field widths, fixed-point formats, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package mpls_pkg;

	localparam int SAMPLE_WIDTH     = 16;
	localparam int FRAC_BITS        = SAMPLE_WIDTH - 1;
	localparam int MAX_VERTICES_DEF = 8;

	localparam int THR_W      = 15;
	localparam int CNT_W      = 4;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// datapath widths
	localparam int M_W     = SAMPLE_WIDTH;          // blend, 0 .. 2^15
	localparam int X_W     = SAMPLE_WIDTH + 1;      // mirrored signal
	localparam int MUL_W   = 2 * SAMPLE_WIDTH + 2;  // (up - lo) * m
	localparam int VOUT_W  = 2 * SAMPLE_WIDTH + 1;  // vertex output, Q.30
	localparam int DIFF_W  = VOUT_W + 1;
	localparam int DX_W    = SAMPLE_WIDTH + 1;
	localparam int PROD_W  = DIFF_W + DX_W + 1;
	localparam int Y_W     = DIFF_W + 1;
	localparam int SCL_W   = Y_W + SAMPLE_WIDTH;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER  = 3'd0,
		REG_LOWER  = 3'd1,
		REG_MIRROR = 3'd2,
		REG_SCALE  = 3'd3,
		REG_COUNT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MSET, S_MWAIT, S_SEARCH, S_VA, S_VB, S_DIFF, S_MUL,
		S_IDIV, S_IWAIT, S_SCALE, S_OUT
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] in_lvl;
		logic signed [SAMPLE_WIDTH-1:0] up;
		logic signed [SAMPLE_WIDTH-1:0] lo;
	} vertex_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/core/mpls_cell.sv
// ----------------------------------------------------------------------------
// mpls_cell: one curve vertex
// Holds a vertex and tests whether the signal falls in the segment that
// starts here, using the input level handed over by the right neighbor.
// ----------------------------------------------------------------------------
module mpls_cell (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  mpls_pkg::vertex_t                     wr_data,
	input  logic signed [mpls_pkg::X_W-1:0]       x,
	input  logic signed [mpls_pkg::SAMPLE_WIDTH-1:0] next_in,
	input  logic                                  active,
	output mpls_pkg::vertex_t                     vtx,
	output logic                                  hit
);
	import mpls_pkg::*;

	vertex_t vtx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtx_q <= wr_data;
		end
	end

	assign vtx = vtx_q;
	// degenerate segments (equal input levels) never match
	assign hit = active && (vtx_q.in_lvl != next_in) &&
		(x >= X_W'(vtx_q.in_lvl)) && (x < X_W'(next_in));

endmodule

>>> rtl/core/mpls_div.sv
// ----------------------------------------------------------------------------
// mpls_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, quotient held after done.
// ----------------------------------------------------------------------------
module mpls_div #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      dividend,
	input  logic [DEN_W-1:0]      divisor,
	output mpls_pkg::div_stat_t   stat,
	output logic [NUM_W-1:0]      quotient
);
	import mpls_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

>>> rtl/core/modulated_piecewise_linear_shaper_top.sv
// ----------------------------------------------------------------------------
// modulated_piecewise_linear_shaper_top: modulated waveshaper, Q1.15
// Vertex table as a row of cells, a shared serial divider, a sequencer.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries two kinds of beat, told apart by tuser: a sample beat
//   (sample_in, modulation) and a vertex-write beat (index, input level,
//   upper and lower output level). A vertex write leaves the sequencer idle and
//   returns nothing. A sample beat returns one m_axis beat: the shaped
//   sample in tdata and segment_found in tuser.
//   The cfg channel writes the five registers; cfg_ready is always high.
//   Write registers only while no sample is in flight.
// Throughput
//   One sample at a time: a new sample is accepted only once the last one
//   has left the sequencer. A sample passes through the bit-serial divider
//   up to twice (blend factor, then interpolation fraction).
// Reset
//   arst_n clears the registers (vertex count 2, all else 0) and the
//   sequencer; the vertex table holds garbage until written.
// Stall
//   A finished result waits in the output register; the next sample is
//   still accepted and worked on, and holds in its last step only if the
//   output register is still full.
// ----------------------------------------------------------------------------
module modulated_piecewise_linear_shaper_top #(
	parameter int MAX_VERTICES = mpls_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// stream in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: sample_in, modulation, vertex_index, vertex_in_level,
	//        vertex_upper_out, vertex_lower_out, zero fill to 88 bits
	input  logic [87:0]                         s_axis_tdata,
	// tuser: req_type
	input  logic [0:0]                          s_axis_tuser,
	// stream out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: sample_out
	output logic [mpls_pkg::SAMPLE_WIDTH-1:0]   m_axis_tdata,
	// tuser: segment_found
	output logic [0:0]                          m_axis_tuser,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpls_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpls_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mpls_pkg::*;

	localparam int W     = SAMPLE_WIDTH;
	localparam int SEG_W = $clog2(MAX_VERTICES);
	localparam logic signed [SCL_W-1:0] SAT_HI = SCL_W'((1 << (W - 1)) - 1);
	localparam logic signed [SCL_W-1:0] SAT_LO = -SAT_HI - SCL_W'(1);

	// ---------------- unpack the input beat ----------------
	logic                 req_type;
	logic signed [W-1:0]  sample_in;
	logic signed [W-1:0]  modulation;
	logic [IDX_W-1:0]     vertex_index;
	vertex_t              wr_vtx;

	assign req_type        = s_axis_tuser[0];
	assign sample_in       = s_axis_tdata[15:0];
	assign modulation      = s_axis_tdata[31:16];
	assign vertex_index    = s_axis_tdata[34:32];
	assign wr_vtx.in_lvl   = s_axis_tdata[50:35];
	assign wr_vtx.up       = s_axis_tdata[66:51];
	assign wr_vtx.lo       = s_axis_tdata[82:67];

	// ---------------- configuration registers ----------------
	logic [THR_W-1:0] upper_q;
	logic [THR_W-1:0] lower_q;
	logic             mirror_q;
	logic             scale_q;
	logic [CNT_W-1:0] cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q  <= '0;
			lower_q  <= '0;
			mirror_q <= 1'b0;
			scale_q  <= 1'b0;
			cnt_q    <= CNT_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_UPPER:  upper_q  <= cfg_data[THR_W-1:0];
				REG_LOWER:  lower_q  <= cfg_data[THR_W-1:0];
				REG_MIRROR: mirror_q <= cfg_data[0];
				REG_SCALE:  scale_q  <= cfg_data[0];
				REG_COUNT:  cnt_q    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the vertex count to 2 .. MAX_VERTICES
	logic [CNT_W-1:0] n_eff;
	always_comb begin
		if (cnt_q < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (cnt_q > CNT_W'(MAX_VERTICES)) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = cnt_q;
		end
	end

	// ---------------- sequencer ----------------
	seq_state_t state_q, state_d;
	logic       in_beat;
	logic       sample_beat;
	logic       vtx_beat;
	logic       out_load;

	logic               out_valid_q;
	logic [W-1:0]       out_data_q;
	logic               out_found_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign sample_beat   = in_beat && !req_type;
	assign vtx_beat      = in_beat && req_type;

	// ---------------- row of vertex cells ----------------
	vertex_t              cell_vtx [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] cell_hit;
	logic signed [X_W-1:0] x_q;

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		logic signed [W-1:0] nb_in;
		logic                act;
		if (i + 1 < MAX_VERTICES) begin : g_nb
			assign nb_in = cell_vtx[i+1].in_lvl;
		end else begin : g_end
			assign nb_in = '0;
		end
		assign act = (CNT_W'(i + 1) < n_eff);

		mpls_cell u_cell (
			.clk     (clk),
			.wr_en   (vtx_beat && (vertex_index == IDX_W'(i))),
			.wr_data (wr_vtx),
			.x       (x_q),
			.next_in (nb_in),
			.active  (act),
			.vtx     (cell_vtx[i]),
			.hit     (cell_hit[i])
		);
	end

	// first matching segment in table order
	logic       seg_found;
	vertex_t    seg_a;
	vertex_t    seg_b;
	always_comb begin
		seg_found = 1'b0;
		seg_a     = cell_vtx[n_eff[SEG_W-1:0] - SEG_W'(1)];
		seg_b     = cell_vtx[0];
		for (int i = MAX_VERTICES - 2; i >= 0; i--) begin
			if (cell_hit[i]) begin
				seg_found = 1'b1;
				seg_a     = cell_vtx[i];
				seg_b     = cell_vtx[i+1];
			end
		end
	end

	// ---------------- shared divider ----------------
	logic              div_start;
	logic [PROD_W-1:0] div_num;
	logic [DX_W-1:0]   div_den;
	div_stat_t         div_stat;
	logic [PROD_W-1:0] div_quo;

	mpls_div #(
		.NUM_W (PROD_W),
		.DEN_W (DX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ---------------- datapath registers ----------------
	logic signed [W-1:0]      raw_q;
	logic [W-1:0]             mag_q;
	logic                     neg_q;
	logic [M_W-1:0]           m_q;
	logic                     found_q;
	vertex_t                  a_q;
	vertex_t                  b_q;
	logic [DX_W-1:0]          dx_q;
	logic [DX_W-1:0]          span_q;
	logic signed [VOUT_W-1:0] oa_q;
	logic signed [VOUT_W-1:0] ob_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [Y_W-1:0]    y_q;
	logic signed [SCL_W-1:0]  scl_q;

	// blend factor thresholds, swapped when reversed
	logic [THR_W-1:0] thr_hi;
	logic [THR_W-1:0] thr_lo;
	logic [THR_W:0]   thr_rng;
	logic [W:0]       mag_off;
	assign thr_hi  = (upper_q < lower_q) ? lower_q : upper_q;
	assign thr_lo  = (upper_q < lower_q) ? upper_q : lower_q;
	assign thr_rng = {1'b0, thr_hi} - {1'b0, thr_lo};
	assign mag_off = {1'b0, mag_q} - (W + 1)'(thr_lo);

	// vertex output: lo * 2^15 + (up - lo) * m, one multiplier for both ends
	vertex_t                  v_sel;
	logic signed [W:0]        v_ul;
	logic signed [MUL_W-1:0]  v_full;
	logic signed [VOUT_W-1:0] vout_c;
	assign v_sel  = (state_q == S_VB) ? b_q : a_q;
	assign v_ul   = (W + 1)'(v_sel.up) - (W + 1)'(v_sel.lo);
	assign v_full = (v_ul * $signed({1'b0, m_q})) + (MUL_W'(v_sel.lo) <<< FRAC_BITS);
	assign vout_c = v_full[VOUT_W-1:0];

	// interpolation quotient, truncated toward zero
	logic signed [Y_W-1:0] q_signed;
	assign q_signed = prod_q[PROD_W-1] ? -$signed(div_quo[Y_W-1:0])
		: $signed(div_quo[Y_W-1:0]);

	// floor to Q1.15 and saturate
	logic signed [SCL_W-1:0] scl_sh;
	logic [W-1:0]            sat_c;
	assign scl_sh = scale_q ? (scl_q >>> (2 * FRAC_BITS)) : (scl_q >>> FRAC_BITS);
	always_comb begin
		if (scl_sh > SAT_HI) begin
			sat_c = SAT_HI[W-1:0];
		end else if (scl_sh < SAT_LO) begin
			sat_c = SAT_LO[W-1:0];
		end else begin
			sat_c = scl_sh[W-1:0];
		end
	end

	// next state and divider control
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (sample_beat) state_d = S_MSET;
			end
			S_MSET: begin
				if (mag_q <= W'(thr_lo) || mag_off >= (W + 1)'(thr_rng)) begin
					state_d = S_SEARCH;
				end else begin
					div_start = 1'b1;
					div_num   = PROD_W'(mag_off) << FRAC_BITS;
					div_den   = DX_W'(thr_rng);
					state_d   = S_MWAIT;
				end
			end
			S_MWAIT: begin
				if (div_stat.done) state_d = S_SEARCH;
			end
			S_SEARCH: state_d = S_VA;
			S_VA: state_d = found_q ? S_VB : S_SCALE;
			S_VB: state_d = S_DIFF;
			S_DIFF: state_d = S_MUL;
			S_MUL: state_d = S_IDIV;
			S_IDIV: begin
				div_start = 1'b1;
				div_num   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
				div_den   = span_q;
				state_d   = S_IWAIT;
			end
			S_IWAIT: begin
				if (div_stat.done) state_d = S_SCALE;
			end
			S_SCALE: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath, advanced by the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (sample_beat) begin
					raw_q <= sample_in;
					mag_q <= modulation[W-1] ? W'(-modulation) : W'(modulation);
					neg_q <= mirror_q && sample_in[W-1];
					x_q   <= (mirror_q && sample_in[W-1]) ? -X_W'(sample_in)
						: X_W'(sample_in);
				end
			end
			S_MSET: begin
				if (mag_q <= W'(thr_lo)) begin
					m_q <= '0;
				end else begin
					m_q <= M_W'(1 << FRAC_BITS);
				end
			end
			S_MWAIT: begin
				if (div_stat.done) m_q <= div_quo[M_W-1:0];
			end
			S_SEARCH: begin
				found_q <= seg_found;
				a_q     <= seg_a;
				b_q     <= seg_b;
				dx_q    <= DX_W'(x_q - X_W'(seg_a.in_lvl));
				span_q  <= DX_W'(X_W'(seg_b.in_lvl) - X_W'(seg_a.in_lvl));
			end
			S_VA: begin
				oa_q <= vout_c;
				y_q  <= Y_W'(vout_c);
			end
			S_VB: ob_q <= vout_c;
			S_DIFF: diff_q <= DIFF_W'(ob_q) - DIFF_W'(oa_q);
			S_MUL: prod_q <= diff_q * $signed({1'b0, dx_q});
			S_IWAIT: begin
				if (div_stat.done) y_q <= Y_W'(oa_q) + q_signed;
			end
			S_SCALE: begin
				if (scale_q) begin
					scl_q <= y_q * raw_q;
				end else begin
					scl_q <= neg_q ? -SCL_W'(y_q) : SCL_W'(y_q);
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q  <= sat_c;
			out_found_q <= found_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_found_q;

endmodule

>>> rtl/core/mpls_checker.sv
// ----------------------------------------------------------------------------
// mpls_checker: port-level checks for the shaper
// Output stall behavior, input-side turnaround of both beat kinds, and no early result.
// ----------------------------------------------------------------------------
module mpls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [mpls_pkg::SAMPLE_WIDTH-1:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);
	import mpls_pkg::*;

	logic sample_in_beat;
	logic vtx_in_beat;
	assign sample_in_beat = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];
	assign vtx_in_beat    = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result changed while stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in_beat |=> !s_axis_tready)
		else $error("input open while a sample is in work");

	a_vtx_turn: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_in_beat |=> s_axis_tready)
		else $error("vertex write did not return to idle");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in_beat |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

endmodule

bind modulated_piecewise_linear_shaper_top mpls_checker u_mpls_checker (.*);

>>> verif/tb_modulated_piecewise_linear_shaper_top.sv
// ----------------------------------------------------------------------------
// tb_modulated_piecewise_linear_shaper_top: self-checking bench for the shaper
// Loads vertex tables and register settings, streams sample and vertex-write
// beats under random flow control, and checks every shaped sample against an
// in-bench fixed-point model of the curve.
// ----------------------------------------------------------------------------
module tb_modulated_piecewise_linear_shaper_top;
	import mpls_pkg::*;

	localparam int N_VTX      = 8;
	localparam int DRAIN_WAIT = 150;   // settle wait after the last result is back
	localparam int WDOG_LIMIT = 5000;  // cycles without any accepted beat

	// Shaped-sample model and store of pending shaped samples.
	class shaper_scoreboard;
		logic [SAMPLE_WIDTH-1:0] pend_sample[$];
		logic                    pend_found[$];
		int                      errors;
		bit [THR_W-1:0]          thr_upper, thr_lower;
		bit                      mirror, scale;
		bit [CNT_W-1:0]          count;
		longint                  lvl[N_VTX], v_up[N_VTX], v_lo[N_VTX];

		function new();
			count = 2;
		endfunction

		function void set_reg(cfg_reg_t r, bit [CFG_DATA_W-1:0] d);
			case (r)
				REG_UPPER:  thr_upper = d[THR_W-1:0];
				REG_LOWER:  thr_lower = d[THR_W-1:0];
				REG_MIRROR: mirror = d[0];
				REG_SCALE:  scale = d[0];
				REG_COUNT:  count = d[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Vertex output in Q.30 at blend m.
		function longint blend_level(int i, longint m);
			return v_lo[i] * 32768 + (v_up[i] - v_lo[i]) * m;
		endfunction

		function void note_beat(logic [87:0] d, logic kind);
			longint raw, modv, x, sgn, hi, lo, range, mag, m, y, oa, ob, r;
			int     n, seg, idx;
			bit     found;
			if (kind) begin
				idx = int'(d[34:32]);
				lvl[idx]  = longint'($signed(d[50:35]));
				v_up[idx] = longint'($signed(d[66:51]));
				v_lo[idx] = longint'($signed(d[82:67]));
				return;
			end
			raw  = longint'($signed(d[15:0]));
			modv = longint'($signed(d[31:16]));
			x = raw;
			sgn = 1;
			if (mirror && raw < 0) begin
				x = -raw;
				sgn = -1;
			end
			hi = thr_upper;
			lo = thr_lower;
			if (hi < lo) begin
				hi = thr_lower;
				lo = thr_upper;
			end
			range = hi - lo;
			mag = (modv < 0) ? -modv : modv;
			if (mag <= lo)
				m = 0;
			else if (mag - lo >= range)
				m = 32768;
			else
				m = ((mag - lo) * 32768) / range;
			n = count;
			if (n < 2) n = 2;
			if (n > N_VTX) n = N_VTX;
			found = 0;
			seg = 0;
			for (int i = 0; i + 1 < n; i++) begin
				if (!found && lvl[i] != lvl[i+1] && x >= lvl[i] && x < lvl[i+1]) begin
					found = 1;
					seg = i;
				end
			end
			if (found) begin
				oa = blend_level(seg, m);
				ob = blend_level(seg + 1, m);
				y = oa + ((ob - oa) * (x - lvl[seg])) / (lvl[seg+1] - lvl[seg]);
			end else begin
				y = blend_level(n - 1, m);
			end
			// arithmetic shift floors toward minus infinity
			if (scale)
				r = (y * raw) >>> (2 * FRAC_BITS);
			else
				r = (y * sgn) >>> FRAC_BITS;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			pend_sample.push_back(r[SAMPLE_WIDTH-1:0]);
			pend_found.push_back(found);
		endfunction

		function void check_result(logic [SAMPLE_WIDTH-1:0] d, logic f);
			logic [SAMPLE_WIDTH-1:0] es;
			logic                    ef;
			if (pend_sample.size() == 0) begin
				$display("%0t: unexpected result sample_out=%h segment_found=%b",
					$time, d, f);
				errors++;
				return;
			end
			es = pend_sample.pop_front();
			ef = pend_found.pop_front();
			if (d !== es) begin
				$display("%0t: sample_out mismatch expected %h actual %h", $time, es, d);
				errors++;
			end
			if (f !== ef) begin
				$display("%0t: segment_found mismatch expected %b actual %b",
					$time, ef, f);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [SAMPLE_WIDTH-1:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	shaper_scoreboard shaper_sb;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	modulated_piecewise_linear_shaper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Note every accepted input beat and check every taken result; the model updates in acceptance order.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			shaper_sb.note_beat(s_axis_tdata, s_axis_tuser[0]);
		if (m_axis_tvalid && m_axis_tready)
			shaper_sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	// Watchdog: count cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: stall at random on the falling edge.
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Pack a beat: sample, modulation, index, input level, upper, lower.
	function automatic logic [87:0] pack_beat(logic [15:0] smp, logic [15:0] modv,
			logic [2:0] idx, logic [15:0] il, logic [15:0] up, logic [15:0] lo);
		return {5'd0, lo, up, il, idx, modv, smp};
	endfunction

	// Present one beat; hold tvalid across back-to-back beats.
	task automatic send_beat(logic kind, logic [87:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	task automatic send_vertex(int idx, int il, int up, int lo);
		send_beat(1'b1, pack_beat(16'($urandom), 16'($urandom), 3'(idx), 16'(il),
			16'(up), 16'(lo)));
	endtask

	task automatic send_sample(int smp, int modv);
		send_beat(1'b0, pack_beat(16'(smp), 16'(modv), 3'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom)));
	endtask

	// Drop tvalid and hold until all shaped samples are back, then settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (shaper_sb.pend_sample.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Hold cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(cfg_reg_t r, int d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= CFG_DATA_W'(d);
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		shaper_sb.set_reg(r, cfg_data);
		@(negedge clk);
	endtask

	task automatic write_all_regs(int up, int lo, int mir, int scl, int cnt);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		// random upper bits on the one-bit and count registers
		write_reg(REG_MIRROR, int'({14'($urandom_range(16383)), 1'(mir)}));
		write_reg(REG_SCALE, int'({14'($urandom_range(16383)), 1'(scl)}));
		write_reg(REG_COUNT, int'({11'($urandom_range(2047)), 4'(cnt)}));
		cfg_valid <= 1'b0;
	endtask

	// Load a whole ascending table; now and then repeat a level.
	task automatic load_table();
		int il;
		il = -32768 + $urandom_range(8000);
		for (int i = 0; i < N_VTX; i++) begin
			send_vertex(i, il, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
			if ($urandom_range(9) != 0)
				il = il + $urandom_range(9000, 1);
			if (il > 32767) il = 32767;
		end
	endtask

	initial begin
		int phase_up[8]  = '{32767, 0,     1000, 0, 0, 20000, 0, 32767};
		int phase_lo[8]  = '{0,     32767, 1000, 0, 0, 5000,  0, 32767};
		int phase_mir[8] = '{0, 1, 0, 1, 1, 0, 0, 1};
		int phase_scl[8] = '{0, 1, 1, 0, 1, 0, 1, 1};
		int phase_cnt[8] = '{8, 8, 5, 0, 15, 1, 3, 9};
		int edge_vals[4] = '{-32768, 32767, 0, -1};
		int r;

		shaper_sb = new();
		send_idle_pct = 35;
		recv_idle_pct = 50;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_UPPER;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: every entry written before any sample, with repeated
		// input levels and extreme output levels.
		send_vertex(0, -32768, 32767, -32768);
		send_vertex(1, -20000, -32768, 32767);
		send_vertex(2, -20000, 1234, -1234);
		send_vertex(3, 0, 32767, 32767);
		send_vertex(4, 0, -32768, -32768);
		send_vertex(5, 10000, 0, -1);
		send_vertex(6, 32767, 16384, -16384);
		send_vertex(7, 32767, -1, 0);
		// reset settings: equal thresholds at zero, two vertices
		foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[3 - i]);
		drain();
		write_all_regs(32767, 0, 1, 1, 8);
		foreach (edge_vals[i]) begin
			send_sample(edge_vals[i], edge_vals[i]);
			send_sample(edge_vals[i], 16384);
		end
		send_sample(-20000, -32768);
		send_sample(10000, 0);
		drain();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 35;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			if (ph == 4 || ph == 6)
				write_all_regs($urandom_range(32767), $urandom_range(32767),
					$urandom_range(1), $urandom_range(1),
					ph == 4 ? phase_cnt[ph] : $urandom_range(8, 2));
			else
				write_all_regs(phase_up[ph], phase_lo[ph], phase_mir[ph],
					phase_scl[ph], phase_cnt[ph]);
			load_table();
			for (int k = 0; k < 140; k++) begin
				r = $urandom_range(99);
				if (k == 70) begin
					// hold the sender until every result is back
					s_axis_tvalid <= 1'b0;
					while (shaper_sb.pend_sample.size() != 0) @(negedge clk);
					@(negedge clk);
				end
				if (r < 4)
					load_table();
				else if (r < 12)
					send_vertex($urandom_range(7), $urandom_range(65535) - 32768,
						$urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
				else if (r < 20)
					send_sample(edge_vals[$urandom_range(3)], edge_vals[$urandom_range(3)]);
				else
					send_sample($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (shaper_sb.pend_sample.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (shaper_sb.errors == 0 && shaper_sb.pend_sample.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mpls_pkg.sv
rtl/core/mpls_cell.sv
rtl/core/mpls_div.sv
rtl/core/modulated_piecewise_linear_shaper_top.sv
rtl/core/mpls_checker.sv
verif/tb_modulated_piecewise_linear_shaper_top.sv
